// ===== rtl/ebbc_pkg.sv =====
package ebbc_pkg;

  localparam int NAME_MAX = 13;
  localparam int NAME_IDX_W = $clog2(NAME_MAX);
  localparam int NAME_LEN_W = $clog2(NAME_MAX + 1);
  localparam int POS_W = 7;
  localparam int DESC_OFF_W = 5;

  localparam logic [POS_W-1:0] POS_MANUF_HI = 7'd8;
  localparam logic [POS_W-1:0] POS_MANUF_LO = 7'd9;
  localparam logic [POS_W-1:0] DESC_FIRST = 7'd54;
  localparam logic [POS_W-1:0] DESC_END = 7'd126;
  localparam logic [POS_W-1:0] LAST_POS = 7'd127;
  localparam logic [DESC_OFF_W-1:0] DESC_OFF_LAST = 5'd17;
  localparam logic [DESC_OFF_W-1:0] DESC_OFF_PREFIX0 = 5'd0;
  localparam logic [DESC_OFF_W-1:0] DESC_OFF_PREFIX1 = 5'd1;
  localparam logic [DESC_OFF_W-1:0] DESC_OFF_TAG = 5'd3;
  localparam logic [DESC_OFF_W-1:0] DESC_OFF_DATA = 5'd5;
  localparam logic [DESC_OFF_W-1:0] DESC_OFF_RANGE_LAST = 5'd8;

  localparam logic [7:0] TAG_NAME = 8'hFC;
  localparam logic [7:0] TAG_RANGE = 8'hFD;
  localparam logic [7:0] NAME_END = 8'h0A;

  typedef struct packed {
    logic       block_start;
    logic [7:0] edid_byte;
  } edid_in_t;

  typedef struct packed {
    logic        header_ok;
    logic        checksum_ok;
    logic [14:0] manufacturer;
    logic        name_found;
    logic [7:0]  name_char;
    logic        range_found;
    logic [7:0]  vert_min_hz;
    logic [7:0]  vert_max_hz;
    logic [7:0]  horiz_min_khz;
    logic [7:0]  horiz_max_khz;
    logic        last;
  } edid_out_t;

  // One finished block as handed from the parser to the burst generator.
  // name_len is zero when there is no name to emit.
  typedef struct packed {
    logic                         header_ok;
    logic                         checksum_ok;
    logic [14:0]                  manufacturer;
    logic                         name_found;
    logic [NAME_LEN_W-1:0]        name_len;
    logic                         range_found;
    logic [3:0][7:0]              range_values;
    logic [NAME_MAX-1:0][7:0]     name_chars;
  } ebbc_summary_t;

  // Fixed EDID header: 00 FF FF FF FF FF FF 00.
  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] value;
    value = ((idx == 3'd0) || (idx == 3'd7)) ? 8'h00 : 8'hFF;
    return value;
  endfunction

endpackage

// ===== rtl/ebbc_front.sv =====
module ebbc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  ebbc_pkg::edid_in_t     byte_data,
  input  logic                   full,
  output logic                   push,
  output ebbc_pkg::ebbc_summary_t summary
);
  import ebbc_pkg::*;

  logic [POS_W-1:0]      byte_position;
  logic [7:0]            running_sum;
  logic                  header_match;
  logic [15:0]           manufacturer_bytes;
  logic                  descriptor_prefix_ok;
  logic [7:0]            descriptor_tag;
  logic [DESC_OFF_W-1:0] desc_off;
  logic [NAME_LEN_W-1:0] name_length;
  logic                  name_ended;
  logic                  name_seen;
  logic                  range_seen;
  logic [3:0][7:0]       range_values;
  logic [NAME_MAX-1:0][7:0] name_chars;

  logic                  accept;
  logic [POS_W-1:0]      pos;
  logic                  clr;
  logic [7:0]            b;
  logic [7:0]            sum_next;
  logic                  in_desc;
  logic                  data_off;
  logic                  name_wr;
  logic [DESC_OFF_W-1:0] range_off;

  assign byte_stall = full;
  assign accept = byte_valid && !byte_stall;
  assign b = byte_data.edid_byte;
  assign pos = byte_data.block_start ? '0 : byte_position;
  assign clr = (pos == '0);
  assign sum_next = (clr ? 8'd0 : running_sum) + b;
  assign in_desc = (pos >= DESC_FIRST) && (pos < DESC_END);
  assign data_off = (desc_off >= DESC_OFF_DATA) && descriptor_prefix_ok;
  assign range_off = desc_off - DESC_OFF_DATA;
  assign name_wr = in_desc && data_off && (descriptor_tag == TAG_NAME) && !name_ended &&
                   (b != NAME_END) && (name_length < NAME_LEN_W'(NAME_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum <= '0;
      header_match <= 1'b1;
      manufacturer_bytes <= '0;
      descriptor_prefix_ok <= 1'b0;
      descriptor_tag <= '0;
      desc_off <= '0;
      name_length <= '0;
      name_ended <= 1'b0;
      name_seen <= 1'b0;
      range_seen <= 1'b0;
      range_values <= '0;
    end else if (accept) begin
      byte_position <= pos + 1'b1;
      running_sum <= sum_next;
      desc_off <= ((pos < DESC_FIRST) || (desc_off == DESC_OFF_LAST)) ? '0 :
                  desc_off + 1'b1;
      if (clr) begin
        header_match <= (b == header_byte(3'd0));
        manufacturer_bytes <= '0;
        descriptor_prefix_ok <= 1'b0;
        descriptor_tag <= '0;
        name_length <= '0;
        name_ended <= 1'b0;
        name_seen <= 1'b0;
        range_seen <= 1'b0;
        range_values <= '0;
      end else if (pos < POS_MANUF_HI) begin
        header_match <= header_match && (b == header_byte(pos[2:0]));
      end else if (pos == POS_MANUF_HI) begin
        manufacturer_bytes[15:8] <= b;
      end else if (pos == POS_MANUF_LO) begin
        manufacturer_bytes[7:0] <= b;
      end else if (in_desc) begin
        if (desc_off == DESC_OFF_PREFIX0) begin
          descriptor_prefix_ok <= (b == 8'h00);
        end else if (desc_off == DESC_OFF_PREFIX1) begin
          descriptor_prefix_ok <= descriptor_prefix_ok && (b == 8'h00);
        end else if (desc_off == DESC_OFF_TAG) begin
          descriptor_tag <= b;
          if (descriptor_prefix_ok && (b == TAG_NAME)) begin
            name_seen <= 1'b1;
            name_length <= '0;
            name_ended <= 1'b0;
          end else if (descriptor_prefix_ok && (b == TAG_RANGE)) begin
            range_seen <= 1'b1;
          end
        end else if (data_off) begin
          if (descriptor_tag == TAG_NAME) begin
            if (!name_ended) begin
              if (b == NAME_END) begin
                name_ended <= 1'b1;
              end else if (name_length < NAME_LEN_W'(NAME_MAX)) begin
                name_length <= name_length + 1'b1;
              end
            end
          end else if ((descriptor_tag == TAG_RANGE) && (desc_off <= DESC_OFF_RANGE_LAST)) begin
            range_values[range_off[1:0]] <= b;
          end
        end
      end
    end
  end

  // Name characters are only read below name_length, so they need no reset.
  always_ff @(posedge clk) begin
    if (accept && name_wr) begin
      name_chars[name_length[NAME_IDX_W-1:0]] <= b;
    end
  end

  // Byte 127 changes nothing but the sum, so the snapshot uses the new sum
  // and the current values of everything else.
  assign push = accept && (pos == LAST_POS);

  always_comb begin
    summary.header_ok = header_match;
    summary.checksum_ok = (sum_next == 8'd0);
    summary.manufacturer = manufacturer_bytes[14:0];
    summary.name_found = name_seen;
    summary.name_len = name_seen ? name_length : '0;
    summary.range_found = range_seen;
    summary.range_values = range_values;
    summary.name_chars = name_chars;
  end

endmodule

// ===== rtl/ebbc_queue.sv =====
module ebbc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ebbc_pkg::ebbc_summary_t push_data,
  input  logic                    pop,
  output ebbc_pkg::ebbc_summary_t head,
  output logic                    full,
  output logic                    empty
);
  import ebbc_pkg::*;

  ebbc_summary_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/ebbc_back.sv =====
module ebbc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  ebbc_pkg::ebbc_summary_t head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    result_valid,
  input  logic                    result_stall,
  output ebbc_pkg::edid_out_t     result_data
);
  import ebbc_pkg::*;

  logic [NAME_LEN_W-1:0] char_idx;
  logic [NAME_LEN_W-1:0] burst_len;
  logic                  is_last;
  logic                  accept;

  assign burst_len = (head.name_len == '0) ? NAME_LEN_W'(1) : head.name_len;
  assign is_last = (char_idx == burst_len - 1'b1);
  assign result_valid = !empty;
  assign accept = result_valid && !result_stall;
  assign pop = accept && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx <= '0;
    end else if (accept) begin
      char_idx <= is_last ? '0 : char_idx + 1'b1;
    end
  end

  always_comb begin
    result_data.header_ok = head.header_ok;
    result_data.checksum_ok = head.checksum_ok;
    result_data.manufacturer = head.manufacturer;
    result_data.name_found = head.name_found;
    result_data.name_char = (head.name_len == '0) ? 8'h00 :
                            head.name_chars[char_idx[NAME_IDX_W-1:0]];
    result_data.range_found = head.range_found;
    result_data.vert_min_hz = head.range_values[0];
    result_data.vert_max_hz = head.range_values[1];
    result_data.horiz_min_khz = head.range_values[2];
    result_data.horiz_max_khz = head.range_values[3];
    result_data.last = is_last;
  end

endmodule

// ===== rtl/edid_base_block_checker.sv =====
// EDID base block checker.
// Input channel (byte_valid / byte_stall / byte_data): one EDID byte per
// transaction, in block order. Setting block_start makes that byte byte 0 of
// a new block and throws away any partial block. Bytes are taken one per
// cycle without a gap while byte_stall is low.
// Output channel (result_valid / result_stall / result_data): after byte 127
// the block emits one transaction per monitor name character, or a single
// transaction when there is no name, with last set on the final one. Every
// transaction of the burst repeats the header, checksum, manufacturer and
// range fields.
// The summary of a block is registered into the queue when byte 127 is taken;
// its burst of 1 to 13 results runs at one result per cycle while not stalled.
// A two-entry summary queue separates the byte parser from the burst
// generator, so the next block streams in while a burst is still draining.
// The input stalls only when both queue entries hold undelivered bursts.
// Reset clears the byte position, all per-block state and the queue; name
// characters are not cleared since only written ones are ever emitted.
module edid_base_block_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  ebbc_pkg::edid_in_t   byte_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output ebbc_pkg::edid_out_t  result_data
);
  import ebbc_pkg::*;

  // Handoff between the parser and the burst generator.
  ebbc_summary_t push_data;
  ebbc_summary_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  // The parser tracks byte position, checksum, header match, manufacturer
  // code and descriptor contents, and snapshots a summary at byte 127.
  ebbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .full       (full),
    .push       (push),
    .summary    (push_data)
  );

  // Each entry holds one whole block's summary, including the name text.
  ebbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  // The burst generator walks the name characters of the head entry and
  // releases the entry when the last transaction is taken.
  ebbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

// ===== sim/tb_edid_base_block_checker.sv =====
`timescale 1ns / 100ps

// Scoreboard for the EDID checker. It tracks block parsing on its own, turns every
// completed block into the burst of summaries the block should emit, and checks
// each delivered summary against the oldest one still waiting.
class edid_summary_board;
  localparam logic [63:0] EDID_HEADER = 64'h00FF_FFFF_FFFF_FF00;
  localparam int DESC_SPAN = int'(ebbc_pkg::DESC_OFF_LAST) + 1;

  logic [6:0] position;
  logic [7:0] byte_sum;
  logic header_match;
  logic [15:0] manuf_bytes;
  logic prefix_ok;
  logic [7:0] desc_tag;
  logic [7:0] name_text [ebbc_pkg::NAME_MAX];
  logic [3:0] name_len;
  logic name_ended;
  logic name_seen;
  logic range_seen;
  logic [7:0] range_limits [4];

  ebbc_pkg::edid_out_t expected_summaries [$];
  int mismatches;
  int results_checked;
  int blocks_closed;
  int named_blocks;
  int ranged_blocks;

  function new();
    position = '0;
    foreach (name_text[i]) name_text[i] = '0;
    mismatches = 0;
    results_checked = 0;
    blocks_closed = 0;
    named_blocks = 0;
    ranged_blocks = 0;
    start_block();
  endfunction

  function void start_block();
    byte_sum = '0;
    header_match = 1'b1;
    manuf_bytes = '0;
    prefix_ok = 1'b0;
    desc_tag = '0;
    name_len = '0;
    name_ended = 1'b0;
    name_seen = 1'b0;
    range_seen = 1'b0;
    foreach (range_limits[i]) range_limits[i] = '0;
  endfunction

  function void take_descriptor(int off, logic [7:0] value);
    if (off == ebbc_pkg::DESC_OFF_PREFIX0) begin
      prefix_ok = (value == 8'h00);
    end else if (off == ebbc_pkg::DESC_OFF_PREFIX1) begin
      prefix_ok = prefix_ok && (value == 8'h00);
    end else if (off == ebbc_pkg::DESC_OFF_TAG) begin
      desc_tag = value;
      if (prefix_ok && value == ebbc_pkg::TAG_NAME) begin
        name_seen = 1'b1;
        name_len = '0;
        name_ended = 1'b0;
      end else if (prefix_ok && value == ebbc_pkg::TAG_RANGE) begin
        range_seen = 1'b1;
      end
    end else if (off >= ebbc_pkg::DESC_OFF_DATA && prefix_ok) begin
      if (desc_tag == ebbc_pkg::TAG_NAME) begin
        if (!name_ended) begin
          if (value == ebbc_pkg::NAME_END) begin
            name_ended = 1'b1;
          end else if (name_len < ebbc_pkg::NAME_MAX) begin
            name_text[name_len] = value;
            name_len = name_len + 4'd1;
          end
        end
      end else if (desc_tag == ebbc_pkg::TAG_RANGE && off <= ebbc_pkg::DESC_OFF_RANGE_LAST) begin
        range_limits[off - ebbc_pkg::DESC_OFF_DATA] = value;
      end
    end
  endfunction

  // Called once per accepted byte transaction.
  function void absorb_byte(ebbc_pkg::edid_in_t item);
    int p;
    int count;
    ebbc_pkg::edid_out_t r;
    if (item.block_start) position = '0;
    p = position;
    if (p == 0) start_block();
    byte_sum = byte_sum + item.edid_byte;
    if (p < 8) begin
      header_match = header_match && (item.edid_byte == EDID_HEADER[8*(7-p) +: 8]);
    end else if (p == ebbc_pkg::POS_MANUF_HI) begin
      manuf_bytes[15:8] = item.edid_byte;
    end else if (p == ebbc_pkg::POS_MANUF_LO) begin
      manuf_bytes[7:0] = item.edid_byte;
    end else if (p >= ebbc_pkg::DESC_FIRST && p < ebbc_pkg::DESC_END) begin
      take_descriptor((p - int'(ebbc_pkg::DESC_FIRST)) % DESC_SPAN, item.edid_byte);
    end
    position = position + 7'd1;
    if (p == ebbc_pkg::LAST_POS) begin
      count = (name_seen && name_len != 0) ? int'(name_len) : 1;
      for (int k = 0; k < count; k++) begin
        r.header_ok = header_match;
        r.checksum_ok = (byte_sum == 8'h00);
        r.manufacturer = manuf_bytes[14:0];
        r.name_found = name_seen;
        r.name_char = (name_seen && name_len != 0) ? name_text[k] : 8'h00;
        r.range_found = range_seen;
        r.vert_min_hz = range_limits[0];
        r.vert_max_hz = range_limits[1];
        r.horiz_min_khz = range_limits[2];
        r.horiz_max_khz = range_limits[3];
        r.last = (k == count - 1);
        expected_summaries.push_back(r);
      end
      blocks_closed++;
      if (name_seen) named_blocks++;
      if (range_seen) ranged_blocks++;
    end
  endfunction

  function int outstanding();
    return expected_summaries.size();
  endfunction

  task report(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task compare_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report($sformatf("%s is 0x%0h, expected 0x%0h (result %0d)",
                       field, got, want, results_checked));
    end
  endtask

  task check_summary(ebbc_pkg::edid_out_t got);
    ebbc_pkg::edid_out_t want;
    results_checked++;
    if (expected_summaries.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", results_checked));
      return;
    end
    want = expected_summaries.pop_front();
    compare_field("header_ok", got.header_ok, want.header_ok);
    compare_field("checksum_ok", got.checksum_ok, want.checksum_ok);
    compare_field("manufacturer", got.manufacturer, want.manufacturer);
    compare_field("name_found", got.name_found, want.name_found);
    compare_field("name_char", got.name_char, want.name_char);
    compare_field("range_found", got.range_found, want.range_found);
    compare_field("vert_min_hz", got.vert_min_hz, want.vert_min_hz);
    compare_field("vert_max_hz", got.vert_max_hz, want.vert_max_hz);
    compare_field("horiz_min_khz", got.horiz_min_khz, want.horiz_min_khz);
    compare_field("horiz_max_khz", got.horiz_max_khz, want.horiz_max_khz);
    compare_field("last", got.last, want.last);
  endtask
endclass

module tb_edid_base_block_checker;
  import ebbc_pkg::*;

  // Each side idles for a random time bounded by IDLE_MAX per transaction.
  // The long receiver hold-off has to outlast several blocks streaming in at
  // full rate so that both summary queue entries fill up and the input
  // stalls. The watchdog limit sits well above that hold-off.
  localparam int IDLE_MAX = 13;
  localparam int HOLD_CYCLES = 900;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 32;
  localparam int BLOCK_LEN = int'(LAST_POS) + 1;
  localparam int DESC_SPAN = int'(DESC_OFF_LAST) + 1;

  // Kinds of 18-byte descriptor the block builder can place in a slot.
  typedef enum int {
    DK_TIMING,
    DK_NAME,
    DK_RANGE,
    DK_OTHER_TAG,
    DK_BAD_PREFIX
  } desc_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  edid_in_t byte_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  edid_out_t result_data;

  edid_summary_board board;
  logic [7:0] block_image [BLOCK_LEN];

  // Flags that the stimulus process uses to steer both sides.
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;
  bit hold_req = 1'b0;

  int bytes_sent = 0;
  int stuck_cycles = 0;
  int input_held_cycles = 0;

  edid_base_block_checker dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data(byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one byte and waits until the block takes it. Valid is lowered
  // only when a gap is drawn, so back-to-back bytes keep it high without a
  // second assignment in the same time step.
  task automatic send_byte(input logic start, input logic [7:0] value);
    int gap;
    edid_in_t item;
    gap = quiet_send ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.block_start = start;
    item.edid_byte = value;
    byte_valid <= 1'b1;
    byte_data <= item;
    do @(posedge clk); while (byte_stall !== 1'b0);
    board.absorb_byte(item);
    bytes_sent++;
  endtask

  // Sends the first count bytes of the block image. With mark_start clear,
  // byte 0 only becomes byte 0 if the position wrapped after byte 127.
  task automatic send_block(input int count, input bit mark_start);
    for (int i = 0; i < count; i++) send_byte(mark_start && i == 0, block_image[i]);
  endtask

  // Raw noise: random bytes with the occasional restart marker.
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte($urandom_range(0, 31) == 0, 8'($urandom_range(0, 255)));
    end
  endtask

  // Lowers valid and waits until every expected summary has been delivered.
  task automatic drain();
    byte_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int desc_base(input int slot);
    return int'(DESC_FIRST) + DESC_SPAN * slot;
  endfunction

  // Fills the image with random bytes, optionally with the fixed header in front.
  task automatic fill_block(input bit good_header);
    for (int i = 0; i < BLOCK_LEN; i++) block_image[i] = 8'($urandom_range(0, 255));
    if (good_header) begin
      for (int i = 0; i < 8; i++) block_image[i] = (i == 0 || i == 7) ? 8'h00 : 8'hFF;
    end
  endtask

  // Overwrites one descriptor slot with a descriptor of the given kind. Names
  // shorter than the maximum get the 0x0A terminator; the rest of the payload
  // stays random so that anything after the terminator is exercised too.
  task automatic put_desc(input int slot, input desc_kind_t kind, input int name_len);
    int base;
    logic [7:0] c;
    base = desc_base(slot);
    case (kind)
      DK_TIMING: begin
        if (block_image[base] == 8'h00) block_image[base] = 8'h01;
      end
      DK_NAME: begin
        block_image[base] = 8'h00;
        block_image[base + 1] = 8'h00;
        block_image[base + DESC_OFF_TAG] = TAG_NAME;
        for (int i = 0; i < name_len; i++) begin
          do c = 8'($urandom_range(0, 255)); while (c == NAME_END);
          block_image[base + DESC_OFF_DATA + i] = c;
        end
        if (name_len < NAME_MAX) block_image[base + DESC_OFF_DATA + name_len] = NAME_END;
      end
      DK_RANGE: begin
        block_image[base] = 8'h00;
        block_image[base + 1] = 8'h00;
        block_image[base + DESC_OFF_TAG] = TAG_RANGE;
      end
      DK_OTHER_TAG: begin
        block_image[base] = 8'h00;
        block_image[base + 1] = 8'h00;
        do c = 8'($urandom_range(0, 255)); while (c == TAG_NAME || c == TAG_RANGE);
        block_image[base + DESC_OFF_TAG] = c;
      end
      default: begin
        // A name or range tag behind a prefix that is not all zero.
        if ($urandom_range(0, 1) != 0) begin
          block_image[base] = 8'($urandom_range(1, 255));
          block_image[base + 1] = 8'h00;
        end else begin
          block_image[base] = 8'h00;
          block_image[base + 1] = 8'($urandom_range(1, 255));
        end
        block_image[base + DESC_OFF_TAG] = ($urandom_range(0, 1) != 0) ? TAG_NAME : TAG_RANGE;
      end
    endcase
  endtask

  // Sets byte 127 so that the whole block sums to zero.
  task automatic seal_checksum();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < BLOCK_LEN - 1; i++) s = s + block_image[i];
    block_image[BLOCK_LEN - 1] = 8'h00 - s;
  endtask

  // A random block with random content in every slot. Most blocks get
  // the right header and checksum so that the deeper fields matter.
  task automatic build_random_block();
    fill_block($urandom_range(0, 9) != 0);
    for (int s = 0; s < 4; s++) begin
      put_desc(s, desc_kind_t'($urandom_range(0, 4)), $urandom_range(0, NAME_MAX));
    end
    if ($urandom_range(0, 4) != 0) seal_checksum();
  endtask

  // Receiver. Before each summary transaction it holds stall for a random
  // number of cycles. When the stimulus asks for it, it first holds off for a long
  // stretch, which lets the summary queue fill and the input stall.
  initial begin
    int w;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      w = quiet_recv ? 0 : $urandom_range(0, IDLE_MAX);
      if (w != 0) begin
        result_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
      board.check_summary(result_data);
    end
  end

  // Watchdog: ends the run if no transaction happens on either side for too
  // long. It also counts the cycles in which the block held off its input.
  always @(posedge clk) begin
    if ((byte_valid && byte_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (byte_valid && byte_stall === 1'b1) input_held_cycles <= input_held_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d summaries still expected",
               stuck_cycles, board.outstanding());
      $display("[edid_base_block_checker] ERROR");
      $finish;
    end
  end

  // Stimulus: directed blocks first, then the long receiver hold-off, then
  // random blocks mixed with noise and broken blocks.
  initial begin
    int base;
    int blocks;
    int pick;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // All zeros: the header fails on byte 1, the checksum holds, and every
    // descriptor has a zero prefix with tag 0, which matches nothing.
    for (int i = 0; i < BLOCK_LEN; i++) block_image[i] = 8'h00;
    send_block(BLOCK_LEN, 1'b1);

    // All ones: bad header, bad checksum, and bit 7 of byte 8 must drop out
    // of the manufacturer code.
    for (int i = 0; i < BLOCK_LEN; i++) block_image[i] = 8'hFF;
    send_block(BLOCK_LEN, 1'b1);

    // A full 13-character name with no terminator, range limits at their
    // extremes, a timing descriptor and an unrelated tag.
    fill_block(1'b1);
    block_image[POS_MANUF_HI] = 8'h80;
    block_image[POS_MANUF_LO] = 8'hFF;
    put_desc(0, DK_NAME, NAME_MAX);
    put_desc(1, DK_RANGE, 0);
    base = desc_base(1) + DESC_OFF_DATA;
    block_image[base] = 8'h00;
    block_image[base + 1] = 8'hFF;
    block_image[base + 2] = 8'h00;
    block_image[base + 3] = 8'hFF;
    put_desc(2, DK_TIMING, 0);
    put_desc(3, DK_OTHER_TAG, 0);
    seal_checksum();
    send_block(BLOCK_LEN, 1'b1);

    // An empty name gives a single result with name_found set. Two range
    // descriptors: the later one wins. A name or range tag behind a broken
    // prefix does nothing, and a tag value in byte 126 is only summed.
    fill_block(1'b1);
    block_image[POS_MANUF_HI] = 8'h00;
    block_image[POS_MANUF_LO] = 8'h00;
    put_desc(0, DK_NAME, 0);
    put_desc(1, DK_RANGE, 0);
    put_desc(2, DK_BAD_PREFIX, 0);
    put_desc(3, DK_RANGE, 0);
    block_image[BLOCK_LEN - 2] = TAG_NAME;
    seal_checksum();
    send_block(BLOCK_LEN, 1'b1);

    // Two names: the second, shorter one replaces the first. Checksum left
    // random.
    fill_block(1'b1);
    put_desc(0, DK_NAME, 5);
    put_desc(1, DK_BAD_PREFIX, 0);
    put_desc(2, DK_TIMING, 0);
    put_desc(3, DK_NAME, 2);
    send_block(BLOCK_LEN, 1'b1);

    // Restart in the middle of a block, inside the first name descriptor.
    fill_block(1'b1);
    put_desc(0, DK_NAME, 7);
    seal_checksum();
    send_block(70, 1'b1);

    // The block that replaces it carries a one-character name in the last slot.
    fill_block(1'b1);
    put_desc(3, DK_NAME, 1);
    seal_checksum();
    send_block(BLOCK_LEN, 1'b1);

    // Next block without the start marker: the position wraps on its own.
    fill_block(1'b1);
    put_desc(1, DK_RANGE, 0);
    put_desc(2, DK_NAME, 12);
    seal_checksum();
    send_block(BLOCK_LEN, 1'b0);
    drain();

    // Receiver holds off for a long stretch while the sender streams blocks
    // at full rate, so the summary queue fills and the input must stall.
    hold_req = 1'b1;
    quiet_send = 1'b1;
    for (int b = 0; b < 5; b++) begin
      build_random_block();
      send_block(BLOCK_LEN, 1'b1);
    end
    quiet_send = 1'b0;
    drain();

    // Random phase. Some blocks run with no idling on one or both sides;
    // a few are cut short or replaced by noise.
    blocks = 0;
    while ((board.results_checked < 80 || blocks < 15) && blocks < 40) begin
      quiet_send = ($urandom_range(0, 4) == 0);
      quiet_recv = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_noise(BLOCK_LEN);
      end else if (pick <= 2) begin
        build_random_block();
        send_block($urandom_range(1, BLOCK_LEN - 1), 1'b1);
      end else begin
        build_random_block();
        send_block(BLOCK_LEN, $urandom_range(0, 7) != 0);
        blocks++;
      end
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d closed blocks (%0d with a name, %0d with range limits), %0d bytes.",
             board.blocks_closed, board.named_blocks, board.ranged_blocks, bytes_sent);
    $display("%0d summary results compared, %0d mismatches, input stalled for %0d cycles.",
             board.results_checked, board.mismatches, input_held_cycles);
    if (board.mismatches == 0) begin
      $display("[edid_base_block_checker] OK");
    end else begin
      $display("[edid_base_block_checker] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ebbc_pkg.sv
rtl/ebbc_front.sv
rtl/ebbc_queue.sv
rtl/ebbc_back.sv
rtl/edid_base_block_checker.sv
sim/tb_edid_base_block_checker.sv
